// File: design/ngh_pkg.sv
`default_nettype none

package ngh_pkg;

  // Request codes carried by req_type.
  localparam logic REQ_INGEST = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CHAR_BASE     = 2'd0;
  localparam logic [1:0] CFG_ALPHABET_SIZE = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LEN     = 2'd2;

  // Register reset values.
  localparam logic [7:0] CHAR_BASE_RST     = 8'd97;
  localparam logic [4:0] ALPHABET_SIZE_RST = 5'd16;
  localparam logic [2:0] BLOCK_LEN_RST     = 3'd4;

  // Line terminator; it empties the window.
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // capture the accepted beat
    logic chk;        // fold the current window byte into the prefix index
    logic rd;         // read the count of the current prefix
    logic wr;         // write back the incremented count, step to next level
    logic qstep;      // one step of the query limit and level base
    logic qrd;        // read the queried count
    logic clr;        // clear one store entry
    logic fin;        // load the result register
    logic fin_bad;    // result is a rejected query
    logic fin_count;  // result carries the count just read
  } ngh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic newline;
    logic window_full;
    logic qlvl_bad;
    logic byte_ok;
    logic walk_last;
    logic q_last;
    logic qidx_bad;
    logic clr_last;
    logic out_free;
  } ngh_stat_t;

  // Integer power, used at elaboration only.
  function automatic longint unsigned ngh_ipow(input int unsigned b, input int unsigned n);
    longint unsigned p;
    p = 1;
    for (int unsigned k = 0; k < n; k++) begin
      p = p * b;
    end
    return p;
  endfunction

  // Entries in the count store: one level per prefix length.
  function automatic longint unsigned ngh_store_depth(input int unsigned max_a,
                                                      input int unsigned max_b);
    longint unsigned p;
    longint unsigned d;
    p = 1;
    d = 0;
    for (int unsigned k = 0; k < max_b; k++) begin
      p = p * max_a;
      d = d + p;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: design/ngram_prefix_histogram.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// cfg       in         cfg_write             cfg_index, cfg_data
// in        in         in_valid / in_stall   req_type, char_byte, query_level, query_index
// out       out        out_valid / out_stall levels_updated, count_value, query_bad
//
// One item at a time: a beat is taken only once the last result is loaded. A newline, a
// short line or a query level past the window goes straight to the result; a full window
// runs check, store read and store write per counted level, and one more check when a
// byte ends the walk early. Other queries run one limit step per level, then an index check.
// Reset starts a clearing pass of one store entry a cycle (69904 at defaults) under in_stall.
// A result waiting under out_stall holds back only the next result, not the next accept.
module ngram_prefix_histogram #(
  parameter int MAX_ALPHABET = 16,
  parameter int MAX_BLOCK    = 4,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  char_byte,
  input  logic [1:0]  query_level,
  input  logic [15:0] query_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  levels_updated,
  output logic [31:0] count_value,
  output logic        query_bad
);
  import ngh_pkg::*;

  ngh_cmd_t  cmd;
  ngh_stat_t st;

  // Sequencer.
  ngh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Window, index arithmetic, count store and result register.
  ngh_dp #(
    .MAX_ALPHABET (MAX_ALPHABET),
    .MAX_BLOCK    (MAX_BLOCK),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .char_byte      (char_byte),
    .query_level    (query_level),
    .query_index    (query_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .levels_updated (levels_updated),
    .count_value    (count_value),
    .query_bad      (query_bad)
  );

endmodule

`default_nettype wire

// File: design/ngh_ctrl.sv
`default_nettype none

module ngh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ngh_pkg::ngh_stat_t st,
  output ngh_pkg::ngh_cmd_t  cmd
);
  import ngh_pkg::*;

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DISP     = 4'd2;
  localparam logic [3:0] ST_WALK_CHK = 4'd3;
  localparam logic [3:0] ST_WALK_RD  = 4'd4;
  localparam logic [3:0] ST_WALK_WR  = 4'd5;
  localparam logic [3:0] ST_Q_STEP   = 4'd6;
  localparam logic [3:0] ST_Q_CHK    = 4'd7;
  localparam logic [3:0] ST_FIN      = 4'd8;
  localparam logic [3:0] ST_FIN_BAD  = 4'd9;
  localparam logic [3:0] ST_FIN_CNT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // New beats are taken only between items and after the clearing pass.
  assign in_stall = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (st.is_query) begin
          state_next = st.qlvl_bad ? ST_FIN_BAD : ST_Q_STEP;
        end else if (st.newline || !st.window_full) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (st.byte_ok) begin
          cmd.chk    = 1'b1;
          state_next = ST_WALK_RD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_WALK_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        cmd.wr     = 1'b1;
        state_next = st.walk_last ? ST_FIN : ST_WALK_CHK;
      end
      ST_Q_STEP: begin
        cmd.qstep = 1'b1;
        if (st.q_last) begin
          state_next = ST_Q_CHK;
        end
      end
      ST_Q_CHK: begin
        if (st.qidx_bad) begin
          state_next = ST_FIN_BAD;
        end else begin
          cmd.qrd    = 1'b1;
          state_next = ST_FIN_CNT;
        end
      end
      ST_FIN: begin
        if (st.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIN_BAD: begin
        if (st.out_free) begin
          cmd.fin     = 1'b1;
          cmd.fin_bad = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_FIN_CNT: begin
        if (st.out_free) begin
          cmd.fin       = 1'b1;
          cmd.fin_count = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> st.out_free)
    else $error("result loaded while the output register is still held");

  a_wr_next: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_WR) |=> (state == ST_WALK_CHK || state == ST_FIN))
    else $error("walk write not followed by next level or result");

  a_clr_exit: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_CLR && state != ST_CLR) |-> $past(st.clr_last))
    else $error("clearing pass left before the last entry");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> (state == ST_IDLE))
    else $error("no return to idle after a result");
`endif

endmodule

`default_nettype wire

// File: design/ngh_dp.sv
`default_nettype none

module ngh_dp #(
  parameter int MAX_ALPHABET = 16,
  parameter int MAX_BLOCK    = 4,
  parameter int COUNT_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ngh_pkg::ngh_cmd_t  cmd,
  output ngh_pkg::ngh_stat_t st,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               req_type,
  input  logic [7:0]         char_byte,
  input  logic [1:0]         query_level,
  input  logic [15:0]        query_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         levels_updated,
  output logic [31:0]        count_value,
  output logic               query_bad
);
  import ngh_pkg::*;

  localparam longint unsigned STORE_DEPTH = ngh_store_depth(MAX_ALPHABET, MAX_BLOCK);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W  = $clog2(ngh_ipow(MAX_ALPHABET, MAX_BLOCK));
  localparam int AL_W   = $clog2(MAX_ALPHABET + 1);
  localparam int LVL_W  = $clog2(MAX_BLOCK + 1);
  localparam int PTR_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  // Queries reach at most four levels.
  localparam int LIM_W  = 4 * AL_W;
  localparam int CMP_W  = (LIM_W > 16) ? LIM_W : 16;
  localparam int SUM_W  = (ADDR_W > 16) ? ADDR_W : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [7:0] char_base;
  logic [4:0] alphabet_size;
  logic [2:0] block_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_base     <= CHAR_BASE_RST;
      alphabet_size <= ALPHABET_SIZE_RST;
      block_len     <= BLOCK_LEN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CHAR_BASE:     char_base     <= cfg_data;
        CFG_ALPHABET_SIZE: alphabet_size <= cfg_data[4:0];
        CFG_BLOCK_LEN:     block_len     <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // Effective alphabet size and window length, clamped to the build limits.
  logic [AL_W-1:0]  a_eff;
  logic [LVL_W-1:0] len_eff;

  always_comb begin
    priority if (alphabet_size == 5'd0) begin
      a_eff = AL_W'(1);
    end else if (int'(alphabet_size) > MAX_ALPHABET) begin
      a_eff = AL_W'(MAX_ALPHABET);
    end else begin
      a_eff = AL_W'(alphabet_size);
    end
    priority if (block_len == 3'd0) begin
      len_eff = LVL_W'(1);
    end else if (int'(block_len) > MAX_BLOCK) begin
      len_eff = LVL_W'(MAX_BLOCK);
    end else begin
      len_eff = LVL_W'(block_len);
    end
  end

  // Captured request and the sliding window of the current line.
  logic             req_r;
  logic             nl_r;
  logic [1:0]       qlvl_r;
  logic [15:0]      qidx_r;
  logic [7:0]       window [MAX_BLOCK];
  logic [LVL_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r  <= req_type;
      nl_r   <= (char_byte == NEWLINE_BYTE);
      qlvl_r <= query_level;
      qidx_r <= query_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < MAX_BLOCK; i++) begin
        window[i] <= '0;
      end
    end else if (cmd.start && req_type == REQ_INGEST) begin
      if (char_byte == NEWLINE_BYTE) begin
        fill <= '0;
      end else begin
        for (int i = 0; i < MAX_BLOCK - 1; i++) begin
          window[i] <= window[i + 1];
        end
        window[MAX_BLOCK - 1] <= char_byte;
        if (fill != LVL_W'(MAX_BLOCK)) begin
          fill <= fill + LVL_W'(1);
        end
      end
    end
  end

  // Walk and query registers: level, prefix index, level base and radix power.
  logic [LVL_W-1:0]  lvl;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] pow;
  logic [LIM_W-1:0]  lim;

  logic [LVL_W:0]         ptr_full;
  logic [PTR_W-1:0]       ptr;
  logic [7:0]             cur_byte;
  logic [7:0]             digit;
  logic [IDX_W+AL_W-1:0]  idx_prod;
  logic [IDX_W+AL_W-1:0]  idx_sum;
  logic [ADDR_W-1:0]      walk_addr;
  logic [SUM_W-1:0]       q_sum;
  logic [ADDR_W-1:0]      q_addr;
  logic [LIM_W+AL_W-1:0]  lim_prod;
  logic [ADDR_W-1:0]      pow_next;
  logic [9:0]             hi_bound;

  // Window byte for the current level: the window's last len_eff bytes.
  assign ptr_full  = (LVL_W + 1)'(MAX_BLOCK) - {1'b0, len_eff} + {1'b0, lvl};
  assign ptr       = ptr_full[PTR_W-1:0];
  assign cur_byte  = window[ptr];
  assign digit     = cur_byte - char_base;
  assign hi_bound  = {2'b00, char_base} + 10'(a_eff);

  // Mixed-radix step: first byte most significant.
  assign idx_prod  = idx * a_eff;
  assign idx_sum   = idx_prod + (IDX_W + AL_W)'(digit);
  assign walk_addr = base + ADDR_W'(idx);
  assign q_sum     = SUM_W'(base) + SUM_W'(qidx_r);
  assign q_addr    = q_sum[ADDR_W-1:0];
  assign lim_prod  = lim * a_eff;
  assign pow_next  = ADDR_W'(pow * ADDR_W'(MAX_ALPHABET));

  // Level l starts at MAX_ALPHABET + ... + MAX_ALPHABET^l, so the step added after
  // level 0 is MAX_ALPHABET itself.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lvl  <= '0;
      idx  <= '0;
      base <= '0;
      pow  <= ADDR_W'(MAX_ALPHABET);
      lim  <= LIM_W'(1);
    end else if (cmd.chk) begin
      idx <= idx_sum[IDX_W-1:0];
    end else if (cmd.wr) begin
      lvl  <= lvl + LVL_W'(1);
      base <= base + pow;
      pow  <= pow_next;
    end else if (cmd.qstep) begin
      lim <= lim_prod[LIM_W-1:0];
      if (!st.q_last) begin
        lvl  <= lvl + LVL_W'(1);
        base <= base + pow;
        pow  <= pow_next;
      end
    end
  end

  // Count store with one write and one registered read port.
  logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] count_inc;
  logic [ADDR_W-1:0]     addr_r;
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  mem_we;
  logic                  mem_re;

  assign count_inc = (rdata == COUNT_MAX) ? rdata : rdata + COUNT_BITS'(1);
  assign mem_re    = cmd.rd || cmd.qrd;
  assign rd_addr   = cmd.qrd ? q_addr : walk_addr;
  assign mem_we    = cmd.clr || cmd.wr;
  assign wr_addr   = cmd.clr ? clr_addr : addr_r;
  assign wr_data   = cmd.clr ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.rd) begin
      addr_r <= walk_addr;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // Counts read out at 32 bits, saturating when wider.
  logic [31:0] rd_clip;

  generate
    if (COUNT_BITS > 32) begin : g_clip_wide
      assign rd_clip = (|rdata[COUNT_BITS-1:32]) ? 32'hFFFF_FFFF : rdata[31:0];
    end else if (COUNT_BITS == 32) begin : g_clip_same
      assign rd_clip = rdata;
    end else begin : g_clip_narrow
      assign rd_clip = {{(32 - COUNT_BITS){1'b0}}, rdata};
    end
  endgenerate

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      levels_updated <= (cmd.fin_bad || cmd.fin_count) ? 3'd0 : 3'(lvl);
      count_value    <= cmd.fin_count ? rd_clip : 32'd0;
      query_bad      <= cmd.fin_bad;
    end
  end

  // Status to the controller.
  always_comb begin
    st.is_query    = (req_r == REQ_QUERY);
    st.newline     = nl_r;
    st.window_full = (fill >= len_eff);
    st.qlvl_bad    = (int'(qlvl_r) >= int'(len_eff));
    st.byte_ok     = ({2'b00, cur_byte} >= {2'b00, char_base}) &&
                     ({2'b00, cur_byte} < hi_bound);
    st.walk_last   = (LVL_W'(lvl + LVL_W'(1)) == len_eff);
    st.q_last      = (int'(lvl) == int'(qlvl_r));
    st.qidx_bad    = (CMP_W'(qidx_r) >= CMP_W'(lim));
    st.clr_last    = (clr_addr == ADDR_W'(STORE_DEPTH - 1));
    st.out_free    = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// File: bench/prefix_count_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the prefix histogram,
// keeps its own copy of the window and the count table, and compares every
// result beat with the oldest outstanding prediction.
module prefix_count_checker #(
  parameter int MAX_ALPHABET = 16,
  parameter int MAX_BLOCK    = 4,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  char_byte,
  input  logic [1:0]  query_level,
  input  logic [15:0] query_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  levels_updated,
  input  logic [31:0] count_value,
  input  logic        query_bad,
  output int unsigned responses_due,
  output int unsigned mismatches
);
  import ngh_pkg::*;

  typedef struct packed {
    logic [2:0]  levels;
    logic [31:0] count;
    logic        bad;
  } response_t;

  localparam longint unsigned COUNT_CEIL = {64{1'b1}} >> (64 - COUNT_BITS);

  // Shadow copy of the registers, the line window and the count table.
  logic [7:0]      cfg_base;
  logic [4:0]      cfg_alpha;
  logic [2:0]      cfg_len;
  logic [7:0]      win [MAX_BLOCK];
  int unsigned     win_fill;
  longint unsigned counts [longint unsigned];
  response_t       pending_responses [$];
  int unsigned     due_now = 0;
  int unsigned     fail_total = 0;

  assign responses_due = due_now;
  assign mismatches    = fail_total;

  function automatic int unsigned alpha_in_use();
    if (cfg_alpha == 0) return 1;
    if (cfg_alpha > MAX_ALPHABET) return MAX_ALPHABET;
    return cfg_alpha;
  endfunction

  function automatic int unsigned levels_in_use();
    if (cfg_len == 0) return 1;
    if (cfg_len > MAX_BLOCK) return MAX_BLOCK;
    return cfg_len;
  endfunction

  // Each level is laid out for the full alphabet, one level after the other.
  function automatic longint unsigned level_offset(input int unsigned lvl);
    longint unsigned base;
    longint unsigned span;
    base = 0;
    span = 1;
    for (int unsigned j = 0; j < lvl; j++) begin
      span = span * MAX_ALPHABET;
      base = base + span;
    end
    return base;
  endfunction

  // Applies one request beat to the shadow state and returns its result.
  function automatic response_t histogram_update(input logic req, input logic [7:0] b,
                                                 input logic [1:0] lvl, input logic [15:0] idx);
    response_t       rsp;
    int unsigned     a;
    int unsigned     len;
    int unsigned     sym_byte;
    longint unsigned limit;
    longint unsigned key;
    longint unsigned prefix;
    longint unsigned c;
    rsp = '0;
    a = alpha_in_use();
    len = levels_in_use();

    // A count read is rejected when the level or the index lies outside the settings.
    if (req == REQ_QUERY) begin
      limit = 1;
      for (int unsigned j = 0; j <= lvl; j++) begin
        limit = limit * a;
      end
      if (lvl >= len || idx >= limit) begin
        rsp.bad = 1'b1;
      end else begin
        key = level_offset(lvl) + idx;
        c = counts.exists(key) ? counts[key] : 0;
        rsp.count = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
      end
      return rsp;
    end

    // A newline starts a new line; the old bytes stay but no longer count as held.
    if (b == NEWLINE_BYTE) begin
      win_fill = 0;
      return rsp;
    end

    for (int k = 0; k < MAX_BLOCK - 1; k++) begin
      win[k] = win[k + 1];
    end
    win[MAX_BLOCK - 1] = b;
    if (win_fill < MAX_BLOCK) win_fill++;

    // Walk the prefixes of a full window until the first byte outside the alphabet.
    if (win_fill >= len) begin
      prefix = 0;
      for (int unsigned l = 0; l < len; l++) begin
        sym_byte = win[MAX_BLOCK - len + l];
        if (sym_byte < cfg_base || sym_byte >= cfg_base + a) break;
        prefix = prefix * a + (sym_byte - cfg_base);
        key = level_offset(l) + prefix;
        c = counts.exists(key) ? counts[key] : 0;
        if (c < COUNT_CEIL) counts[key] = c + 1;
        rsp.levels = rsp.levels + 3'd1;
      end
    end
    return rsp;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_total++;
    end
  endfunction

  // Results are retired before new beats are predicted, so an early result is never
  // matched against the prediction of the beat accepted at the same edge.
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      cfg_base  = CHAR_BASE_RST;
      cfg_alpha = ALPHABET_SIZE_RST;
      cfg_len   = BLOCK_LEN_RST;
      foreach (win[k]) win[k] = 8'd0;
      win_fill = 0;
      counts.delete();
      pending_responses.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, actual levels %0d count %0d bad %0d",
                   $time, levels_updated, count_value, query_bad);
          fail_total++;
        end else begin
          want = pending_responses.pop_front();
          check_field("levels_updated", want.levels, levels_updated);
          check_field("count_value", want.count, count_value);
          check_field("query_bad", want.bad, query_bad);
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_CHAR_BASE:     cfg_base  = cfg_data;
          CFG_ALPHABET_SIZE: cfg_alpha = cfg_data[4:0];
          CFG_BLOCK_LEN:     cfg_len   = cfg_data[2:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        pending_responses.push_back(histogram_update(req_type, char_byte, query_level,
                                                     query_index));
      end
    end
    due_now <= pending_responses.size();
  end

endmodule

// File: bench/tb_ngram_prefix_histogram.sv
`timescale 1ns / 1ps

module tb_ngram_prefix_histogram;
  import ngh_pkg::*;

  localparam int MAX_ALPHABET  = 16;
  localparam int MAX_BLOCK     = 4;
  localparam int COUNT_BITS    = 32;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int FIXED_PHASES  = 11;
  localparam int ALL_PHASES    = 13;
  localparam int PHASE_BEATS   = 96;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_CHAR_BASE;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_INGEST;
  logic [7:0]  char_byte = 8'd0;
  logic [1:0]  query_level = 2'd0;
  logic [15:0] query_index = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  levels_updated;
  logic [31:0] count_value;
  logic        query_bad;
  int unsigned results_due;
  int unsigned mismatches;

  // Settings in force, as the stimulus sees them (alphabet and length already clamped).
  int unsigned base_now = CHAR_BASE_RST;
  int unsigned alpha_now = ALPHABET_SIZE_RST;
  int unsigned len_now = BLOCK_LEN_RST;

  // Last bytes sent on the current line, used to aim reads at counts that exist.
  logic [7:0]  line_tail [MAX_BLOCK];
  int unsigned tail_fill = 0;

  bit          gaps_on = 1'b1;
  int unsigned run_left = 0;
  int unsigned cycle_count = 0;

  // Register settings per phase: first byte code, alphabet size, window length.
  int unsigned phase_base  [FIXED_PHASES] = '{97, 0, 48, 250, 65, 255, 100, 120, 0, 32, 97};
  int unsigned phase_alpha [FIXED_PHASES] = '{16, 1, 2, 16, 3, 31, 0, 5, 16, 4, 2};
  int unsigned phase_len   [FIXED_PHASES] = '{4, 1, 4, 3, 2, 7, 0, 4, 4, 3, 4};

  ngram_prefix_histogram #(
    .MAX_ALPHABET(MAX_ALPHABET),
    .MAX_BLOCK   (MAX_BLOCK),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .char_byte     (char_byte),
    .query_level   (query_level),
    .query_index   (query_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .levels_updated(levels_updated),
    .count_value   (count_value),
    .query_bad     (query_bad)
  );

  prefix_count_checker #(
    .MAX_ALPHABET(MAX_ALPHABET),
    .MAX_BLOCK   (MAX_BLOCK),
    .COUNT_BITS  (COUNT_BITS)
  ) prefix_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .char_byte     (char_byte),
    .query_level   (query_level),
    .query_index   (query_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .levels_updated(levels_updated),
    .count_value   (count_value),
    .query_bad     (query_bad),
    .responses_due (results_due),
    .mismatches    (mismatches)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_span();
    if (!gaps_on || $urandom_range(0, 99) < 55) return 0;
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The receiver alternates stretches of stalls and stretches of free flow.
  always @(posedge clk) begin
    if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if (gaps_on && $urandom_range(0, 1) == 1) begin
      out_stall <= 1'b1;
      run_left  <= idle_span();
    end else begin
      out_stall <= 1'b0;
      run_left  <= $urandom_range(0, 12);
    end
  end

  // Offers one beat after an optional gap and returns at the edge that takes it.
  task automatic send_beat(input logic req, input logic [7:0] b, input logic [1:0] lvl,
                           input logic [15:0] idx);
    int unsigned gap;
    gap = idle_span();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    char_byte   <= b;
    query_level <= lvl;
    query_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    if (req == REQ_INGEST) begin
      if (b == NEWLINE_BYTE) begin
        tail_fill = 0;
      end else begin
        for (int k = 0; k < MAX_BLOCK - 1; k++) line_tail[k] = line_tail[k + 1];
        line_tail[MAX_BLOCK - 1] = b;
        if (tail_fill < MAX_BLOCK) tail_fill++;
      end
    end
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges.
  task automatic set_config(input int unsigned base, input int unsigned alpha,
                            input int unsigned len);
    cfg_write <= 1'b1;
    cfg_index <= CFG_CHAR_BASE;
    cfg_data  <= 8'(base);
    @(posedge clk);
    cfg_index <= CFG_ALPHABET_SIZE;
    cfg_data  <= 8'(alpha);
    @(posedge clk);
    cfg_index <= CFG_BLOCK_LEN;
    cfg_data  <= 8'(len);
    @(posedge clk);
    cfg_write <= 1'b0;
    base_now  = base;
    alpha_now = (alpha == 0) ? 1 : ((alpha > MAX_ALPHABET) ? MAX_ALPHABET : alpha);
    len_now   = (len == 0) ? 1 : ((len > MAX_BLOCK) ? MAX_BLOCK : len);
  endtask

  // Index of the level's prefix in the current window, or -1 if it was never counted.
  function automatic int window_prefix_index(input int unsigned lvl);
    int unsigned v;
    int unsigned b;
    if (lvl >= len_now || tail_fill < len_now) return -1;
    v = 0;
    for (int unsigned k = 0; k <= lvl; k++) begin
      b = line_tail[MAX_BLOCK - len_now + k];
      if (b < base_now || b >= base_now + alpha_now) return -1;
      v = v * alpha_now + (b - base_now);
    end
    return v;
  endfunction

  // Mostly text in the alphabet, with newlines, stray bytes and count reads mixed in.
  task automatic random_phase(input int unsigned beats);
    int unsigned narrow;
    int unsigned pick;
    int unsigned lvl;
    int unsigned lim;
    int unsigned code;
    int          idx;
    narrow = alpha_now;
    for (int unsigned n = 0; n < beats; n++) begin
      if ($urandom_range(0, 99) == 0) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        lvl = ($urandom_range(0, 9) != 0) ? $urandom_range(0, len_now - 1) : $urandom_range(0, 3);
        lim = alpha_now ** (lvl + 1);
        pick = $urandom_range(0, 99);
        idx = (pick < 45) ? window_prefix_index(lvl) : -1;
        if (idx < 0) idx = (pick < 85) ? $urandom_range(0, lim - 1) : $urandom_range(0, 65535);
        send_beat(REQ_QUERY, 8'($urandom_range(0, 255)), 2'(lvl), 16'(idx));
      end else if (pick < 31) begin
        // Half the lines use only two symbols so that long prefixes repeat.
        narrow = ($urandom_range(0, 1) == 1) ? 2 : alpha_now;
        send_beat(REQ_INGEST, NEWLINE_BYTE, 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 65535)));
      end else if (pick < 38) begin
        send_beat(REQ_INGEST, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 65535)));
      end else begin
        code = base_now + $urandom_range(0, ((narrow < alpha_now) ? narrow : alpha_now) - 1);
        if (code > 255) code = $urandom_range(0, 255);
        send_beat(REQ_INGEST, 8'(code), 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_config(CHAR_BASE_RST, ALPHABET_SIZE_RST, BLOCK_LEN_RST);

    // Reads of an empty table, including the last entry of the top level and a bad index.
    send_beat(REQ_QUERY, 8'd0, 2'd0, 16'd0);
    send_beat(REQ_QUERY, 8'd0, 2'd3, 16'hFFFF);
    send_beat(REQ_QUERY, 8'd0, 2'd0, 16'd16);

    // Short line, full windows, the last symbol, a symbol just past the alphabet.
    send_beat(REQ_INGEST, "a", 2'd0, 16'd0);
    send_beat(REQ_INGEST, "b", 2'd0, 16'd0);
    send_beat(REQ_INGEST, "c", 2'd0, 16'd0);
    send_beat(REQ_INGEST, "d", 2'd0, 16'd0);
    send_beat(REQ_INGEST, "e", 2'd0, 16'd0);
    send_beat(REQ_INGEST, "p", 2'd0, 16'd0);
    send_beat(REQ_INGEST, "q", 2'd0, 16'd0);

    // Newline, then a window whose first byte stops the walk at once.
    send_beat(REQ_INGEST, NEWLINE_BYTE, 2'd0, 16'd0);
    send_beat(REQ_INGEST, 8'hFF, 2'd3, 16'hFFFF);
    send_beat(REQ_INGEST, 8'h00, 2'd0, 16'd0);
    send_beat(REQ_INGEST, "a", 2'd0, 16'd0);
    send_beat(REQ_INGEST, "a", 2'd0, 16'd0);

    // Counts of the whole first window and of its first byte.
    send_beat(REQ_QUERY, 8'd0, 2'd3, 16'd291);
    send_beat(REQ_QUERY, 8'd0, 2'd0, 16'd0);
    wait_idle();

    // With two levels, reads above the top level and past the index range are bad.
    set_config(97, 16, 2);
    send_beat(REQ_QUERY, 8'd0, 2'd2, 16'd0);
    send_beat(REQ_QUERY, 8'd0, 2'd3, 16'd0);
    send_beat(REQ_QUERY, 8'd0, 2'd1, 16'd255);
    send_beat(REQ_QUERY, 8'd0, 2'd1, 16'd256);
    wait_idle();

    // Random traffic under a series of settings, extremes first, then two drawn at random.
    for (int p = 0; p < ALL_PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        set_config(phase_base[p], phase_alpha[p], phase_len[p]);
      end else begin
        set_config($urandom_range(0, 255), $urandom_range(1, 16), $urandom_range(1, 4));
      end
      gaps_on = (p % 5) != 3;
      random_phase(PHASE_BEATS);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
